// ===== rtl/ftbp_pkg.sv =====
// shared types and constants for the framed task byte parser
// no dependencies; imported by ftbp_result_buf and framed_task_byte_parser_fifo
`default_nettype none

package ftbp_pkg;

  localparam int BYTE_W  = 8;
  localparam int CFG_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_BYTE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL_BYTE   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_MIN    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TASK_MAX    = 4'd3;

  // register reset values
  localparam logic [BYTE_W-1:0] HEADER_BYTE_RST = 8'd0;
  localparam logic [BYTE_W-1:0] TAIL_BYTE_RST   = 8'd255;
  localparam logic [BYTE_W-1:0] TASK_MIN_RST    = 8'd1;
  localparam logic [BYTE_W-1:0] TASK_MAX_RST    = 8'd3;

  // item command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_READ = 1'b1;

  typedef enum logic [2:0] {
    PH_HEADER = 3'b001,
    PH_TASK   = 3'b010,
    PH_TAIL   = 3'b100
  } phase_t;

  typedef struct packed {
    logic              read_ok;
    logic [BYTE_W-1:0] task_out;
    logic              frame_queued;
    logic              frame_dropped;
  } result_t;

endpackage

`default_nettype wire

// ===== rtl/ftbp_result_buf.sv =====
// two-entry result buffer between the memory read stage and the result port
// depends on ftbp_pkg (result_t)
`default_nettype none

module ftbp_result_buf (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push_valid,
  input  wire ftbp_pkg::result_t push_data,
  output      logic              can_push,
  output      logic              head_valid,
  input  wire logic              head_ready,
  output      ftbp_pkg::result_t head_data
);
  import ftbp_pkg::*;

  result_t    slot0;
  result_t    slot1;
  logic [1:0] count;
  logic       pop;
  logic       push;

  assign head_valid = (count != 2'd0);
  assign head_data  = slot0;
  assign pop        = head_valid && head_ready;
  // a full buffer still takes a transfer in the cycle that it drains one
  assign can_push   = (count != 2'd2) || pop;
  assign push       = push_valid && can_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (push && count == 2'd1) begin
        slot0 <= push_data;
      end else begin
        slot0 <= slot1;
      end
      if (push && count == 2'd2) begin
        slot1 <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        slot0 <= push_data;
      end else begin
        slot1 <= push_data;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/framed_task_byte_parser_fifo.sv =====
// top level: frame parser, task ring in a synchronous memory, result buffer
// depends on ftbp_pkg and ftbp_result_buf
//
// channel  signals                                     direction
// item     item_valid item_ready cmd rx_byte           in
// result   result_valid result_ready read_ok task_out  out
//          frame_queued frame_dropped
// config   cfg_valid cfg_ready cfg_index cfg_data      in
//
// one item per cycle while the result port keeps up; each result passes through
// the ring memory read register, then the two-entry result buffer
// rst is synchronous: parser, pointers and registers reset at once, no clearing
// pass; ring entries stay undefined until pushed and are never read before that
// a stalled result port keeps taking items until the buffer and read stage fill
`default_nettype none

module framed_task_byte_parser_fifo #(
  parameter int QUEUE_DEPTH = 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           item_valid,
  output      logic                           item_ready,
  input  wire logic                           cmd,
  input  wire logic [ftbp_pkg::BYTE_W-1:0]    rx_byte,
  output      logic                           result_valid,
  input  wire logic                           result_ready,
  output      logic                           read_ok,
  output      logic [ftbp_pkg::BYTE_W-1:0]    task_out,
  output      logic                           frame_queued,
  output      logic                           frame_dropped,
  input  wire logic                           cfg_valid,
  output      logic                           cfg_ready,
  input  wire logic [ftbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ftbp_pkg::BYTE_W-1:0]    cfg_data
);
  import ftbp_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  logic [BYTE_W-1:0] header_byte;
  logic [BYTE_W-1:0] tail_byte;
  logic [BYTE_W-1:0] task_min;
  logic [BYTE_W-1:0] task_max;

  phase_t            phase;
  phase_t            phase_next;
  logic [BYTE_W-1:0] held_task;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp_inc;
  logic [PTR_W-1:0]  rp_inc;

  logic [BYTE_W-1:0] ring [QUEUE_DEPTH];
  logic [BYTE_W-1:0] rdata;

  logic    accept;
  logic    fifo_empty;
  logic    fifo_full;
  logic    wr_en;
  logic    rd_en;
  logic    hold_en;
  logic    queued_now;
  logic    dropped_now;

  logic    a_valid;
  logic    a_read_ok;
  logic    a_queued;
  logic    a_dropped;
  logic    can_push;
  result_t a_result;
  result_t head;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      header_byte <= HEADER_BYTE_RST;
      tail_byte   <= TAIL_BYTE_RST;
      task_min    <= TASK_MIN_RST;
      task_max    <= TASK_MAX_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HEADER_BYTE: header_byte <= cfg_data;
        REG_TAIL_BYTE:   tail_byte   <= cfg_data;
        REG_TASK_MIN:    task_min    <= cfg_data;
        REG_TASK_MAX:    task_max    <= cfg_data;
        default: ;
      endcase
    end
  end

  // read stage reloads when empty or when its result moves on
  assign item_ready = !a_valid || can_push;
  assign accept     = item_valid && item_ready;

  assign wp_inc     = (wp == PTR_LAST) ? '0 : wp + PTR_W'(1);
  assign rp_inc     = (rp == PTR_LAST) ? '0 : rp + PTR_W'(1);
  assign fifo_empty = (rp == wp);
  assign fifo_full  = (wp_inc == rp);

  // parser; the header test wins over everything else
  always_comb begin
    phase_next  = phase;
    hold_en     = 1'b0;
    queued_now  = 1'b0;
    dropped_now = 1'b0;
    if (cmd == CMD_BYTE) begin
      if (rx_byte == header_byte) begin
        phase_next = PH_TASK;
      end else begin
        case (phase)
          PH_TASK: begin
            if (rx_byte >= task_min && rx_byte <= task_max) begin
              hold_en    = 1'b1;
              phase_next = PH_TAIL;
            end else begin
              phase_next = PH_HEADER;
            end
          end
          PH_TAIL: begin
            if (rx_byte == tail_byte) begin
              queued_now  = !fifo_full;
              dropped_now = fifo_full;
            end
            phase_next = PH_HEADER;
          end
          default: phase_next = phase;
        endcase
      end
    end
  end

  assign wr_en = accept && queued_now;
  assign rd_en = accept && (cmd == CMD_READ) && !fifo_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      held_task <= '0;
      wp        <= '0;
      rp        <= '0;
    end else if (accept) begin
      phase <= phase_next;
      if (hold_en) begin
        held_task <= rx_byte;
      end
      if (wr_en) begin
        wp <= wp_inc;
      end
      if (rd_en) begin
        rp <= rp_inc;
      end
    end
  end

  // task ring; one item either writes or reads, so no same-entry overlap
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[wp] <= held_task;
    end
    if (rd_en) begin
      rdata <= ring[rp];
    end
  end

  // read stage flags travel beside the memory read register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (accept) begin
      a_valid <= 1'b1;
    end else if (can_push) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_read_ok <= rd_en;
      a_queued  <= queued_now;
      a_dropped <= dropped_now;
    end
  end

  always_comb begin
    a_result.read_ok       = a_read_ok;
    a_result.task_out      = a_read_ok ? rdata : '0;
    a_result.frame_queued  = a_queued;
    a_result.frame_dropped = a_dropped;
  end

  ftbp_result_buf u_result_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (a_valid),
    .push_data  (a_result),
    .can_push   (can_push),
    .head_valid (result_valid),
    .head_ready (result_ready),
    .head_data  (head)
  );

  assign read_ok       = head.read_ok;
  assign task_out      = head.task_out;
  assign frame_queued  = head.frame_queued;
  assign frame_dropped = head.frame_dropped;

  // a pop only happens on a non-empty ring
  a_rd_nonempty: assert property (@(posedge clk) disable iff (rst)
    rd_en |-> (rp != wp))
    else $error("ring read while empty");

  // a push leaves the ring non-empty
  a_wr_fills: assert property (@(posedge clk) disable iff (rst)
    wr_en |=> (rp != wp))
    else $error("ring empty after push");

  // a byte result never carries task data
  a_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !read_ok) |-> (task_out == '0))
    else $error("task_out set without read_ok");

  // a frame is either queued or dropped, and never on a read
  a_frame_excl: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(frame_queued && frame_dropped) &&
                     !(read_ok && (frame_queued || frame_dropped)))
    else $error("conflicting result flags");

endmodule

`default_nettype wire
